[design/sil_ops_pkg.sv]
package sil_ops_pkg;

   localparam int LIST_DEPTH = 32;
   localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int ID_W       = 32;
   localparam int UNIV_W     = 7;

   localparam logic [UNIV_W-1:0] UNIV_LIMIT = 7'd64;

   typedef enum logic [2:0] {
      CMD_CLEAR      = 3'd0,
      CMD_LOAD_LEFT  = 3'd1,
      CMD_LOAD_RIGHT = 3'd2,
      CMD_INTERSECT  = 3'd3,
      CMD_UNION      = 3'd4,
      CMD_COMPLEMENT = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_STEP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [2:0]      command;
      logic [ID_W-1:0] doc_id;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0] result_id;
      logic            last;
      logic            empty_res;
      logic            overflow;
   } rsp_type;

endpackage

[design/sorted_id_list_set_ops_top.sv]
// Clear and load requests are taken one per cycle while no run is active
// and produce no result. A run walks the lists in merge steps, each a
// memory read (ST_READ) then a compare (ST_STEP); a step retires at least
// one list entry or one complement number. The final result, held back to
// carry last, is sent from ST_FINISH; requests stall until the run is idle.
// Sync active-high reset clears counts, overflow, universe and control only.
module sorted_id_list_set_ops_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  sil_ops_pkg::req_type             req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output sil_ops_pkg::rsp_type             rsp_data,
   input  logic                             csr_write_en,
   input  logic [sil_ops_pkg::UNIV_W-1:0]   csr_write_data
);

   localparam int ADDR_W = sil_ops_pkg::ADDR_W;
   localparam int CNT_W  = sil_ops_pkg::CNT_W;
   localparam int ID_W   = sil_ops_pkg::ID_W;
   localparam int UNIV_W = sil_ops_pkg::UNIV_W;
   localparam logic [CNT_W-1:0] DEPTH = CNT_W'(sil_ops_pkg::LIST_DEPTH);

   logic [ID_W-1:0] left_mem  [sil_ops_pkg::LIST_DEPTH];
   logic [ID_W-1:0] right_mem [sil_ops_pkg::LIST_DEPTH];
   logic [ID_W-1:0] left_rd_ff, right_rd_ff;

   sil_ops_pkg::state_type state_ff, state_in;
   sil_ops_pkg::cmd_type   op_ff, op_in;
   logic [CNT_W-1:0]  left_cnt_ff, left_cnt_in, right_cnt_ff, right_cnt_in;
   logic [CNT_W-1:0]  lidx_ff, lidx_in, ridx_ff, ridx_in;
   logic [UNIV_W-1:0] dnum_ff, dnum_in, univ_ff, univ_in;
   logic              ovf_ff, ovf_in;
   logic              pend_vld_ff, pend_vld_in;
   logic [ID_W-1:0]   pend_id_ff, pend_id_in;
   logic              rsp_vld_ff, rsp_vld_in;
   sil_ops_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic              req_take, is_run, left_we, right_we;
   logic              out_free, l_more, r_more;
   logic [UNIV_W-1:0] top;
   logic              gen_vld, step_done, step_hold, push;
   logic [ID_W-1:0]   gen_id;
   logic [CNT_W-1:0]  lidx_nx, ridx_nx;
   logic [UNIV_W-1:0] dnum_nx;

   assign req_stall = (state_ff != sil_ops_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign is_run    = (req_data.command == sil_ops_pkg::CMD_INTERSECT)
                   || (req_data.command == sil_ops_pkg::CMD_UNION)
                   || (req_data.command == sil_ops_pkg::CMD_COMPLEMENT);
   assign left_we   = req_take && (req_data.command == sil_ops_pkg::CMD_LOAD_LEFT)
                   && (left_cnt_ff < DEPTH);
   assign right_we  = req_take && (req_data.command == sil_ops_pkg::CMD_LOAD_RIGHT)
                   && (right_cnt_ff < DEPTH);
   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign l_more    = lidx_ff < left_cnt_ff;
   assign r_more    = ridx_ff < right_cnt_ff;
   assign top       = (univ_ff > sil_ops_pkg::UNIV_LIMIT) ? sil_ops_pkg::UNIV_LIMIT : univ_ff;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   // list stores, read every cycle at the current walk pointers
   always_ff @(posedge clock) begin
      if (left_we) begin
         left_mem[left_cnt_ff[ADDR_W-1:0]] <= req_data.doc_id;
      end
      if (right_we) begin
         right_mem[right_cnt_ff[ADDR_W-1:0]] <= req_data.doc_id;
      end
      left_rd_ff  <= left_mem[lidx_ff[ADDR_W-1:0]];
      right_rd_ff <= right_mem[ridx_ff[ADDR_W-1:0]];
   end

   // one merge step on the data read for the current pointers
   always_comb begin
      gen_vld   = 1'b0;
      gen_id    = '0;
      step_done = 1'b0;
      lidx_nx   = lidx_ff;
      ridx_nx   = ridx_ff;
      dnum_nx   = dnum_ff;
      case (op_ff)
         sil_ops_pkg::CMD_INTERSECT: begin
            if (l_more && r_more) begin
               if (left_rd_ff == right_rd_ff) begin
                  gen_vld = 1'b1;
                  gen_id  = left_rd_ff;
                  lidx_nx = lidx_ff + 1'b1;
                  ridx_nx = ridx_ff + 1'b1;
               end else if (left_rd_ff < right_rd_ff) begin
                  lidx_nx = lidx_ff + 1'b1;
               end else begin
                  ridx_nx = ridx_ff + 1'b1;
               end
            end else begin
               step_done = 1'b1;
            end
         end
         sil_ops_pkg::CMD_UNION: begin
            if (!l_more && !r_more) begin
               step_done = 1'b1;
            end else if (!l_more) begin
               gen_vld = 1'b1;
               gen_id  = right_rd_ff;
               ridx_nx = ridx_ff + 1'b1;
            end else if (!r_more) begin
               gen_vld = 1'b1;
               gen_id  = left_rd_ff;
               lidx_nx = lidx_ff + 1'b1;
            end else if (left_rd_ff < right_rd_ff) begin
               gen_vld = 1'b1;
               gen_id  = left_rd_ff;
               lidx_nx = lidx_ff + 1'b1;
            end else if (right_rd_ff < left_rd_ff) begin
               gen_vld = 1'b1;
               gen_id  = right_rd_ff;
               ridx_nx = ridx_ff + 1'b1;
            end else begin
               gen_vld = 1'b1;
               gen_id  = left_rd_ff;
               lidx_nx = lidx_ff + 1'b1;
               ridx_nx = ridx_ff + 1'b1;
            end
         end
         sil_ops_pkg::CMD_COMPLEMENT: begin
            if (dnum_ff > top) begin
               step_done = 1'b1;
            end else begin
               if (l_more && (left_rd_ff == ID_W'(dnum_ff))) begin
                  lidx_nx = lidx_ff + 1'b1;
               end else begin
                  gen_vld = 1'b1;
                  gen_id  = ID_W'(dnum_ff);
               end
               dnum_nx = dnum_ff + 1'b1;
            end
         end
         default: begin
            step_done = 1'b1;
         end
      endcase
      // a new result displaces the held one, which needs the output register
      step_hold = gen_vld && pend_vld_ff && !out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sil_ops_pkg::ST_IDLE: begin
            if (req_take && is_run) begin
               state_in = sil_ops_pkg::ST_READ;
            end
         end
         sil_ops_pkg::ST_READ: begin
            state_in = sil_ops_pkg::ST_STEP;
         end
         sil_ops_pkg::ST_STEP: begin
            if (step_done) begin
               state_in = sil_ops_pkg::ST_FINISH;
            end else if (!step_hold) begin
               state_in = sil_ops_pkg::ST_READ;
            end
         end
         sil_ops_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = sil_ops_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sil_ops_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath updates
   always_comb begin
      op_in        = op_ff;
      left_cnt_in  = left_cnt_ff;
      right_cnt_in = right_cnt_ff;
      ovf_in       = ovf_ff;
      univ_in      = csr_write_en ? csr_write_data : univ_ff;
      lidx_in      = lidx_ff;
      ridx_in      = ridx_ff;
      dnum_in      = dnum_ff;
      pend_vld_in  = pend_vld_ff;
      pend_id_in   = pend_id_ff;
      push         = 1'b0;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         sil_ops_pkg::ST_IDLE: begin
            if (req_take) begin
               case (req_data.command)
                  sil_ops_pkg::CMD_CLEAR: begin
                     left_cnt_in  = '0;
                     right_cnt_in = '0;
                     ovf_in       = 1'b0;
                  end
                  sil_ops_pkg::CMD_LOAD_LEFT: begin
                     if (left_we) begin
                        left_cnt_in = left_cnt_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  sil_ops_pkg::CMD_LOAD_RIGHT: begin
                     if (right_we) begin
                        right_cnt_in = right_cnt_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  sil_ops_pkg::CMD_INTERSECT,
                  sil_ops_pkg::CMD_UNION,
                  sil_ops_pkg::CMD_COMPLEMENT: begin
                     op_in       = sil_ops_pkg::cmd_type'(req_data.command);
                     lidx_in     = '0;
                     ridx_in     = '0;
                     dnum_in     = UNIV_W'(1);
                     pend_vld_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         sil_ops_pkg::ST_STEP: begin
            if (!step_done && !step_hold) begin
               lidx_in = lidx_nx;
               ridx_in = ridx_nx;
               dnum_in = dnum_nx;
               if (gen_vld) begin
                  pend_vld_in = 1'b1;
                  pend_id_in  = gen_id;
                  if (pend_vld_ff) begin
                     push        = 1'b1;
                     rsp_data_in = '{result_id: pend_id_ff, last: 1'b0,
                                     empty_res: 1'b0, overflow: ovf_ff};
                  end
               end
            end
         end
         sil_ops_pkg::ST_FINISH: begin
            if (out_free) begin
               push        = 1'b1;
               pend_vld_in = 1'b0;
               if (pend_vld_ff) begin
                  rsp_data_in = '{result_id: pend_id_ff, last: 1'b1,
                                  empty_res: 1'b0, overflow: ovf_ff};
               end else begin
                  rsp_data_in = '{result_id: '0, last: 1'b1,
                                  empty_res: 1'b1, overflow: ovf_ff};
               end
            end
         end
         default: begin
         end
      endcase
      if (push) begin
         rsp_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sil_ops_pkg::ST_IDLE;
         left_cnt_ff  <= '0;
         right_cnt_ff <= '0;
         ovf_ff       <= 1'b0;
         univ_ff      <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         left_cnt_ff  <= left_cnt_in;
         right_cnt_ff <= right_cnt_in;
         ovf_ff       <= ovf_in;
         univ_ff      <= univ_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      lidx_ff     <= lidx_in;
      ridx_ff     <= ridx_in;
      dnum_ff     <= dnum_in;
      pend_id_ff  <= pend_id_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTH
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (left_cnt_ff <= DEPTH) && (right_cnt_ff <= DEPTH))
      else $error("list count beyond depth");

   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sil_ops_pkg::ST_IDLE) |-> !pend_vld_ff)
      else $error("held result left behind after run");

   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sil_ops_pkg::ST_FINISH) && out_free |=>
      rsp_vld_ff && rsp_data_ff.last)
      else $error("run ended without a last result");

   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_data_ff.empty_res |->
      rsp_data_ff.last && (rsp_data_ff.result_id == '0))
      else $error("malformed empty result");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != sil_ops_pkg::ST_IDLE) |->
      (lidx_ff <= left_cnt_ff) && (ridx_ff <= right_cnt_ff))
      else $error("walk pointer past list end");
`endif

endmodule
